### sv/ttb_pkg.sv
`default_nettype none

package ttb_pkg;

	localparam int NUM_TIMERS = 8;
	localparam int TIMER_W    = 3;
	localparam int TEMPO_W    = 16;
	localparam int PERIOD_W   = 32;
	localparam int CYCLES_W   = 16;
	localparam int SUM_W      = PERIOD_W + 1;
	localparam int DIV_STEPS  = SUM_W;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	localparam logic [4:0] ADDR_STATUS  = 5'd0;
	localparam logic [4:0] ADDR_CONTROL = 5'd1;

	localparam logic [TEMPO_W-1:0] TEMPO_MIN = 16'h0001;

	typedef struct packed {
		logic [1:0]          opcode;
		logic [4:0]          reg_address;
		logic [7:0]          write_data;
		logic [CYCLES_W-1:0] elapsed_cycles;
	} ttb_in_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq;
	} ttb_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_TICK_SUM,
		ST_TICK_CHECK,
		ST_TICK_DIV,
		ST_BPM_DIV,
		ST_DONE
	} ttb_state_t;

	typedef struct packed {
		logic item_load;
		logic idx_clr;
		logic idx_inc;
		logic sum_load;
		logic div_start;
		logic div_sel_tempo;
		logic tempo_wr;
		logic period_wr;
		logic elapsed_wr_sum;
		logic elapsed_wr_rem;
		logic fire;
		logic finish;
	} ttb_cmd_t;

	typedef struct packed {
		logic op_tick;
		logic op_bpm_wr;
		logic idx_last;
		logic sum_lt_p;
		logic div_done;
	} ttb_stat_t;

endpackage

`default_nettype wire

### sv/ttb_chan.sv
`default_nettype none

interface ttb_chan #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### sv/ttb_div.sv
`default_nettype none

module ttb_div import ttb_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [SUM_W-1:0]    dividend,
	input  wire logic [PERIOD_W-1:0] divisor,
	output logic                     busy,
	output logic                     done,
	output logic [SUM_W-1:0]         quotient,
	output logic [PERIOD_W-1:0]      remainder
);

	localparam int CNT_W = $clog2(DIV_STEPS + 1);

	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [SUM_W-1:0]    quo_q;
	logic [PERIOD_W-1:0] div_q;

	logic [SUM_W-1:0] trial;
	logic [SUM_W-1:0] diff;
	logic             ge;

	// restoring step: bring in the next dividend bit, subtract when it fits
	always_comb begin
		trial = {rem_q, quo_q[SUM_W-1]};
		diff  = trial - {1'b0, div_q};
		ge    = trial >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q  <= CNT_W'(DIV_STEPS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

### sv/ttb_datapath.sv
`default_nettype none

module ttb_datapath import ttb_pkg::*; #(
	parameter int CLOCK_RATE = 3000000
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire ttb_cmd_t cmd,
	output ttb_stat_t     stat,
	input  wire ttb_in_t  item,
	output ttb_out_t      result
);

	localparam logic [63:0] BASE_WIDE = 64'(CLOCK_RATE) * 64'd60;
	localparam logic [PERIOD_W-1:0] PERIOD_BASE = BASE_WIDE[PERIOD_W-1:0];

	ttb_in_t             item_q;
	ttb_out_t            result_q;
	logic [TIMER_W-1:0]  idx_q;
	logic [SUM_W-1:0]    sum_q;
	logic [7:0]          status_q;
	logic [7:0]          enable_q;
	logic [TEMPO_W-1:0]  tempo_q   [NUM_TIMERS];
	logic [PERIOD_W-1:0] period_q  [NUM_TIMERS];
	logic [PERIOD_W-1:0] elapsed_q [NUM_TIMERS];

	logic [TIMER_W-1:0]  t_sel;
	logic [TEMPO_W-1:0]  tempo_cur;
	logic [TEMPO_W-1:0]  tempo_mix;
	logic [TEMPO_W-1:0]  tempo_new;
	logic                is_write;
	logic                status_wr;
	logic                control_wr;
	logic [7:0]          newly;
	logic [7:0]          status_next;
	logic [7:0]          rd_data;
	logic [PERIOD_W-1:0] period_cur;

	logic [SUM_W-1:0]    div_dividend;
	logic [PERIOD_W-1:0] div_divisor;
	logic                div_busy;
	logic                div_done;
	logic [SUM_W-1:0]    div_quo;
	logic [PERIOD_W-1:0] div_rem;

	always_comb begin
		t_sel      = item_q.reg_address[TIMER_W:1];
		tempo_cur  = tempo_q[t_sel];
		period_cur = period_q[idx_q];
		if (item_q.reg_address[0]) begin
			tempo_mix = {tempo_cur[15:8], item_q.write_data};
		end else begin
			tempo_mix = {item_q.write_data, tempo_cur[7:0]};
		end
		tempo_new = (tempo_mix == '0) ? TEMPO_MIN : tempo_mix;

		is_write   = item_q.opcode == OP_WRITE;
		status_wr  = is_write && (item_q.reg_address == ADDR_STATUS);
		control_wr = is_write && (item_q.reg_address == ADDR_CONTROL);
		newly      = item_q.write_data & ~enable_q;
		status_next = status_wr ? (status_q & ~item_q.write_data) : status_q;

		rd_data = '0;
		if (item_q.opcode == OP_READ) begin
			priority if (item_q.reg_address == ADDR_STATUS) begin
				rd_data = status_q;
			end else if (item_q.reg_address == ADDR_CONTROL) begin
				rd_data = enable_q;
			end else if (item_q.reg_address[4]) begin
				rd_data = item_q.reg_address[0] ? tempo_cur[7:0] : tempo_cur[15:8];
			end else begin
				rd_data = '0;
			end
		end

		if (cmd.div_sel_tempo) begin
			div_dividend = {1'b0, PERIOD_BASE};
			div_divisor  = {{(PERIOD_W - TEMPO_W){1'b0}}, tempo_new};
		end else begin
			div_dividend = sum_q;
			div_divisor  = period_cur;
		end

		stat.op_tick   = item_q.opcode == OP_TICK;
		stat.op_bpm_wr = is_write && item_q.reg_address[4];
		stat.idx_last  = idx_q == TIMER_W'(NUM_TIMERS - 1);
		stat.sum_lt_p  = sum_q < {1'b0, period_cur};
		stat.div_done  = div_done;
	end

	ttb_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			item_q <= item;
		end
		if (cmd.sum_load) begin
			sum_q <= {1'b0, elapsed_q[idx_q]} + {{(SUM_W - CYCLES_W){1'b0}}, item_q.elapsed_cycles};
		end
		if (cmd.finish) begin
			result_q.read_data <= rd_data;
			result_q.irq       <= |status_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			status_q <= '0;
			enable_q <= '0;
		end else begin
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.fire && enable_q[idx_q]) begin
				status_q[idx_q] <= 1'b1;
			end else if (cmd.finish) begin
				status_q <= status_next;
			end
			if (cmd.finish && control_wr) begin
				enable_q <= item_q.write_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TIMERS; i++) begin
				tempo_q[i]  <= TEMPO_MIN;
				period_q[i] <= PERIOD_BASE;
			end
		end else begin
			if (cmd.tempo_wr) begin
				tempo_q[t_sel] <= tempo_new;
			end
			if (cmd.period_wr) begin
				period_q[t_sel] <= div_quo[PERIOD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TIMERS; i++) begin
				elapsed_q[i] <= '0;
			end
		end else begin
			if (cmd.elapsed_wr_sum) begin
				elapsed_q[idx_q] <= sum_q[PERIOD_W-1:0];
			end else if (cmd.elapsed_wr_rem) begin
				elapsed_q[idx_q] <= div_rem;
			end else if (cmd.finish && control_wr) begin
				// clear counters of timers that turn on
				for (int i = 0; i < NUM_TIMERS; i++) begin
					if (newly[i]) begin
						elapsed_q[i] <= '0;
					end
				end
			end
		end
	end

	assign result = result_q;

	a_div_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !div_busy)
		else $error("division started while one is in flight");

	a_irq_tracks_status: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (result_q.irq == (status_q != '0)))
		else $error("irq does not match status");

	a_tempo_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tempo_wr |=> (tempo_q[t_sel] != '0))
		else $error("tempo left at zero");

endmodule

`default_nettype wire

### sv/ttb_ctrl.sv
`default_nettype none

module ttb_ctrl import ttb_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	input  wire ttb_stat_t stat,
	output ttb_cmd_t       cmd
);

	ttb_state_t state_q;
	ttb_state_t state_d;
	logic       rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.item_load = 1'b1;
					state_d       = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (stat.op_tick) begin
					cmd.idx_clr = 1'b1;
					state_d     = ST_TICK_SUM;
				end else if (stat.op_bpm_wr) begin
					cmd.tempo_wr      = 1'b1;
					cmd.div_sel_tempo = 1'b1;
					cmd.div_start     = 1'b1;
					state_d           = ST_BPM_DIV;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_TICK_SUM: begin
				cmd.sum_load = 1'b1;
				state_d      = ST_TICK_CHECK;
			end
			ST_TICK_CHECK: begin
				if (stat.sum_lt_p) begin
					cmd.elapsed_wr_sum = 1'b1;
					if (stat.idx_last) begin
						state_d = ST_DONE;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = ST_TICK_SUM;
					end
				end else begin
					// wrap: reduce the counter through the divider
					cmd.fire      = 1'b1;
					cmd.div_start = 1'b1;
					state_d       = ST_TICK_DIV;
				end
			end
			ST_TICK_DIV: begin
				if (stat.div_done) begin
					cmd.elapsed_wr_rem = 1'b1;
					if (stat.idx_last) begin
						state_d = ST_DONE;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = ST_TICK_SUM;
					end
				end
			end
			ST_BPM_DIV: begin
				if (stat.div_done) begin
					cmd.period_wr = 1'b1;
					state_d       = ST_DONE;
				end
			end
			ST_DONE: begin
				// hold until the output register is free
				if (!rsp_valid_q || rsp_ready) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the done state");

	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == ST_DECODE))
		else $error("accepted item not decoded");

	a_tick_div_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TICK_DIV && !stat.div_done) |=> (state_q == ST_TICK_DIV))
		else $error("left the divide wait before the divider finished");

endmodule

`default_nettype wire

### sv/tempo_timer_bank.sv
// Eight timers with periods set in beats per minute, reached through a byte
// register bus and advanced by tick items. Every item returns one result
// (read byte, interrupt level). Bus reads and status or control writes go
// from decode straight to the done state. A tick sums and checks the counter
// of each timer in turn; a timer whose counter wraps has the wrap reduced
// by the shared 33-step restoring divider. A tempo byte write waits on the
// same divider computing 60 * CLOCK_RATE / bpm. One item is in work at a
// time; a new item is taken while the previous result waits in the output
// register.
`default_nettype none

module tempo_timer_bank import ttb_pkg::*; #(
	parameter int CLOCK_RATE = 3000000
) (
	input wire logic clk,
	input wire logic arst_n,
	ttb_chan.sink    req,
	ttb_chan.source  rsp
);

	ttb_cmd_t  cmd;
	ttb_stat_t stat;
	ttb_out_t  result;

	ttb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ttb_datapath #(
		.CLOCK_RATE (CLOCK_RATE)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.item   (req.payload),
		.result (result)
	);

	assign rsp.payload = result;

endmodule

`default_nettype wire
